[hw/rtl/segw_pkg.sv]
// ----------------------------------------------------------------------------
// segw_pkg: shared types and constants for the segment slice block
// Coordinate width, lane count and derived widths of the product and
// divider paths, plus the side-band bundle that rides along the divider.
// ----------------------------------------------------------------------------
package segw_pkg;

  // Coordinate word width, two's complement fixed point
  localparam int CoordBits = 32;
  // One lane per spatial coordinate (x, y, z)
  localparam int Lanes     = 3;
  // Numerator width: sum of two CoordBits x CoordBits magnitude products
  localparam int NumBits   = 2 * CoordBits;
  // Divisor width: sum of two weight magnitudes
  localparam int DivBits   = CoordBits + 1;
  // Cycles from accepted beat to result strobe
  localparam int Latency   = CoordBits + 4;

  typedef logic [CoordBits-1:0] coord_t;

  // Per-beat side-band carried through the divider
  typedef struct packed {
    logic             crosses;
    logic [Lanes-1:0] neg;
  } side_t;

endpackage

[hw/rtl/segw_div.sv]
// ----------------------------------------------------------------------------
// segw_div: pipelined restoring divider, three lanes, shared divisor
// One quotient bit per stage, CoordBits stages. A beat enters every cycle;
// its divisor and side-band travel with it. The numerator high half must
// be below the divisor for the quotient to fit in CoordBits.
// ----------------------------------------------------------------------------
module segw_div (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  input  segw_pkg::side_t                           in_side_i,
  input  logic [segw_pkg::Lanes-1:0][segw_pkg::NumBits-1:0] in_num_i,
  input  logic [segw_pkg::DivBits-1:0]              in_den_i,
  output logic                                      out_valid_o,
  output segw_pkg::side_t                           out_side_o,
  output logic [segw_pkg::Lanes-1:0][segw_pkg::CoordBits-1:0] out_quo_o
);
  import segw_pkg::*;

  // Partial remainder plus a shift word: numerator bits leave at the top,
  // quotient bits enter at the bottom.
  typedef struct packed {
    logic [DivBits-1:0]   rem;
    logic [CoordBits-1:0] lo;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [DivBits-1:0] den);
    logic [DivBits:0] sh;
    logic [DivBits:0] diff;
    div_state_t       r;
    sh   = {s.rem, s.lo[CoordBits-1]};
    diff = sh - {1'b0, den};
    if (sh >= {1'b0, den}) begin
      r.rem = diff[DivBits-1:0];
      r.lo  = {s.lo[CoordBits-2:0], 1'b1};
    end else begin
      r.rem = sh[DivBits-1:0];
      r.lo  = {s.lo[CoordBits-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [CoordBits-1:0] vld_q;
  side_t                side_q [CoordBits];
  logic [DivBits-1:0]   den_q  [CoordBits];
  div_state_t           st_q   [CoordBits][Lanes];
  div_state_t           st_d   [CoordBits][Lanes];

  for (genvar k = 0; k < CoordBits; k++) begin : g_stage
    if (k == 0) begin : g_load
      // Step each lane from the loaded numerator
      always_comb begin
        div_state_t src;
        for (int l = 0; l < Lanes; l++) begin
          src.rem    = {1'b0, in_num_i[l][NumBits-1:CoordBits]};
          src.lo     = in_num_i[l][CoordBits-1:0];
          st_d[k][l] = div_step(src, in_den_i);
        end
      end

      // Advance the valid bit
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else begin
          vld_q[k] <= in_valid_i;
        end
      end

      // Advance the payload
      always_ff @(posedge clk_i) begin
        side_q[k] <= in_side_i;
        den_q[k]  <= in_den_i;
      end
    end else begin : g_step
      // Step each lane from the previous stage
      always_comb begin
        for (int l = 0; l < Lanes; l++) begin
          st_d[k][l] = div_step(st_q[k-1][l], den_q[k-1]);
        end
      end

      // Advance the valid bit
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else begin
          vld_q[k] <= vld_q[k-1];
        end
      end

      // Advance the payload
      always_ff @(posedge clk_i) begin
        side_q[k] <= side_q[k-1];
        den_q[k]  <= den_q[k-1];
      end
    end

    // Hold the stepped lane states
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < Lanes; l++) begin
        st_q[k][l] <= st_d[k][l];
      end
    end
  end

  assign out_valid_o = vld_q[CoordBits-1];
  assign out_side_o  = side_q[CoordBits-1];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      out_quo_o[l] = st_q[CoordBits-1][l].lo;
    end
  end

endmodule

[hw/rtl/segment_w_hyperplane_slice_top.sv]
// ----------------------------------------------------------------------------
// segment_w_hyperplane_slice_top: segment slice by the w = 0 hyperplane
// Flags a strict sign change of w between the two endpoints and gives the
// crossing point (|w1|*a0 + |w0|*a1) / (|w0| + |w1|) per coordinate,
// truncated toward zero; zero coordinates when there is no crossing.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   segment | start / busy         | start_{x,y,z,w}_i, end_{x,y,z,w}_i
//   result  | done_o (one cycle)   | crosses_o, cut_x_o, cut_y_o, cut_z_o
//
// One beat is accepted per cycle; busy is never raised.
// Each result is registered after its beat through three arithmetic stages
// (magnitudes, products, signed sum), one divider stage per quotient bit,
// and the output register.
// Reset clears the valid bits and the crossing flag only; results hold for
// one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module segment_w_hyperplane_slice_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  segw_pkg::coord_t start_x_i,
  input  segw_pkg::coord_t start_y_i,
  input  segw_pkg::coord_t start_z_i,
  input  segw_pkg::coord_t start_w_i,
  input  segw_pkg::coord_t end_x_i,
  input  segw_pkg::coord_t end_y_i,
  input  segw_pkg::coord_t end_z_i,
  input  segw_pkg::coord_t end_w_i,
  output logic             done_o,
  output logic             crosses_o,
  output segw_pkg::coord_t cut_x_o,
  output segw_pkg::coord_t cut_y_o,
  output segw_pkg::coord_t cut_z_o
);
  import segw_pkg::*;

  function automatic coord_t mag_of(coord_t v);
    return v[CoordBits-1] ? coord_t'(-v) : v;
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: signs and magnitudes ----------------
  logic               v1_q, v2_q, v3_q;
  logic               cross1_q, cross2_q, cross3_q;
  coord_t             m0_q, m1_q;
  logic [DivBits-1:0] den1_q, den2_q, den3_q;
  coord_t             g0_q [Lanes];
  coord_t             g1_q [Lanes];
  logic [Lanes-1:0]   n0_q, n1_q, n0_2_q, n1_2_q;

  coord_t             a0 [Lanes];
  coord_t             a1 [Lanes];
  logic               cross_d;

  always_comb begin
    a0[0] = start_x_i;
    a0[1] = start_y_i;
    a0[2] = start_z_i;
    a1[0] = end_x_i;
    a1[1] = end_y_i;
    a1[2] = end_z_i;
    cross_d = (start_w_i != '0) && (end_w_i != '0) &&
              (start_w_i[CoordBits-1] != end_w_i[CoordBits-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Capture weight magnitudes, divisor and coordinate sign/magnitude
  always_ff @(posedge clk_i) begin
    cross1_q <= cross_d;
    m0_q     <= mag_of(start_w_i);
    m1_q     <= mag_of(end_w_i);
    den1_q   <= {1'b0, mag_of(start_w_i)} + {1'b0, mag_of(end_w_i)};
    for (int l = 0; l < Lanes; l++) begin
      g0_q[l] <= mag_of(a0[l]);
      g1_q[l] <= mag_of(a1[l]);
      n0_q[l] <= a0[l][CoordBits-1];
      n1_q[l] <= a1[l][CoordBits-1];
    end
  end

  // ---------------- stage 2: weighted products ----------------
  logic [NumBits-1:0] p0_q [Lanes];
  logic [NumBits-1:0] p1_q [Lanes];

  always_ff @(posedge clk_i) begin
    cross2_q <= cross1_q;
    den2_q   <= den1_q;
    n0_2_q   <= n0_q;
    n1_2_q   <= n1_q;
    for (int l = 0; l < Lanes; l++) begin
      p0_q[l] <= NumBits'(m1_q) * NumBits'(g0_q[l]);
      p1_q[l] <= NumBits'(m0_q) * NumBits'(g1_q[l]);
    end
  end

  // ---------------- stage 3: signed sum as sign and magnitude ----------------
  logic [Lanes-1:0][NumBits-1:0] num3_q;
  logic [Lanes-1:0]              neg3_q;

  always_ff @(posedge clk_i) begin
    cross3_q <= cross2_q;
    den3_q   <= den2_q;
    for (int l = 0; l < Lanes; l++) begin
      if (n0_2_q[l] == n1_2_q[l]) begin
        num3_q[l] <= p0_q[l] + p1_q[l];
        neg3_q[l] <= n0_2_q[l];
      end else if (p0_q[l] >= p1_q[l]) begin
        num3_q[l] <= p0_q[l] - p1_q[l];
        neg3_q[l] <= n0_2_q[l];
      end else begin
        num3_q[l] <= p1_q[l] - p0_q[l];
        neg3_q[l] <= n1_2_q[l];
      end
    end
  end

  // ---------------- divider ----------------
  side_t                           side3;
  logic                            dv_valid;
  side_t                           dv_side;
  logic [Lanes-1:0][CoordBits-1:0] dv_quo;

  assign side3.crosses = cross3_q;
  assign side3.neg     = neg3_q;

  segw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_side_i   (side3),
    .in_num_i    (num3_q),
    .in_den_i    (den3_q),
    .out_valid_o (dv_valid),
    .out_side_o  (dv_side),
    .out_quo_o   (dv_quo)
  );

  // ---------------- output register: apply sign, drop non-crossings ----------------
  logic   done_q, crosses_q;
  coord_t cut_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      crosses_q <= 1'b0;
    end else begin
      done_q    <= dv_valid;
      crosses_q <= dv_valid && dv_side.crosses;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      if (!dv_side.crosses) begin
        cut_q[l] <= '0;
      end else if (dv_side.neg[l]) begin
        cut_q[l] <= coord_t'(-dv_quo[l]);
      end else begin
        cut_q[l] <= dv_quo[l];
      end
    end
  end

  assign done_o    = done_q;
  assign crosses_o = crosses_q;
  assign cut_x_o   = cut_q[0];
  assign cut_y_o   = cut_q[1];
  assign cut_z_o   = cut_q[2];

  // ---------------- assertions ----------------
  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted beat did not produce a result on time");

  a_result_has_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result strobe without a matching accepted beat");

  a_crosses_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (crosses_o == $past(cross_d, Latency)))
    else $error("crossing flag does not match the beat's w signs");

  a_no_cross_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !crosses_o) |-> (cut_x_o == '0 && cut_y_o == '0 && cut_z_o == '0))
    else $error("non-crossing result carries nonzero coordinates");

endmodule

[tb/segw_result_checker.sv]
// ----------------------------------------------------------------------------
// segw_result_checker: scoreboard for the segment slice block
// Watches the segment and result channels and predicts the crossing flag
// and crossing point of each accepted segment beat. Compares every result
// beat field by field with the oldest prediction and counts mismatches.
// ----------------------------------------------------------------------------
module segw_result_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  segw_pkg::coord_t start_x_i,
  input  segw_pkg::coord_t start_y_i,
  input  segw_pkg::coord_t start_z_i,
  input  segw_pkg::coord_t start_w_i,
  input  segw_pkg::coord_t end_x_i,
  input  segw_pkg::coord_t end_y_i,
  input  segw_pkg::coord_t end_z_i,
  input  segw_pkg::coord_t end_w_i,
  input  logic             done_i,
  input  logic             crosses_i,
  input  segw_pkg::coord_t cut_x_i,
  input  segw_pkg::coord_t cut_y_i,
  input  segw_pkg::coord_t cut_z_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import segw_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic   crosses;
    coord_t x;
    coord_t y;
    coord_t z;
  } cut_point_t;

  cut_point_t pending_cuts[$];

  // Weighted blend (m1 * a0 + m0 * a1) / (m0 + m1), truncated toward zero
  function automatic coord_t blend_coord(coord_t a0, coord_t a1,
                                         logic signed [67:0] m0,
                                         logic signed [67:0] m1);
    logic signed [67:0] av0;
    logic signed [67:0] av1;
    logic signed [67:0] num;
    logic signed [67:0] quo;
    av0 = $signed(a0);
    av1 = $signed(a1);
    num = m1 * av0 + m0 * av1;
    quo = num / (m0 + m1);
    return quo[CoordBits-1:0];
  endfunction

  // Predict one result from one segment beat
  function automatic cut_point_t slice_segment(coord_t sx, coord_t sy, coord_t sz,
                                               coord_t sw, coord_t ex, coord_t ey,
                                               coord_t ez, coord_t ew);
    cut_point_t         res;
    logic signed [67:0] w0;
    logic signed [67:0] w1;
    logic signed [67:0] m0;
    logic signed [67:0] m1;
    w0 = $signed(sw);
    w1 = $signed(ew);
    m0 = (w0 < 0) ? -w0 : w0;
    m1 = (w1 < 0) ? -w1 : w1;
    res = '0;
    // Strict crossing only: nonzero weights of opposite sign
    if (m0 != 0 && m1 != 0 && sw[CoordBits-1] != ew[CoordBits-1]) begin
      res.crosses = 1'b1;
      res.x = blend_coord(sx, ex, m0, m1);
      res.y = blend_coord(sy, ey, m0, m1);
      res.z = blend_coord(sz, ez, m0, m1);
    end
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Predict on accepted segment beats, compare on result beats
  always @(posedge clk_i) begin
    cut_point_t got;
    cut_point_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        pending_cuts.push_back(slice_segment(start_x_i, start_y_i, start_z_i, start_w_i,
                                             end_x_i, end_y_i, end_z_i, end_w_i));
      end
      if (done_i) begin
        got = '{crosses: crosses_i, x: cut_x_i, y: cut_y_i, z: cut_z_i};
        if (pending_cuts.size() == 0) begin
          if (fail_count_o < ReportLimit) begin
            $display("%0t: result beat with nothing expected: crosses=%0b x=%h y=%h z=%h",
                     $realtime, got.crosses, got.x, got.y, got.z);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_cuts.pop_front();
          if (got.crosses !== want.crosses || got.x !== want.x ||
              got.y !== want.y || got.z !== want.z) begin
            if (fail_count_o < ReportLimit) begin
              $display("%0t: cut point differs: expected crosses=%0b x=%h y=%h z=%h",
                       $realtime, want.crosses, want.x, want.y, want.z);
              $display("%0t:                    actual   crosses=%0b x=%h y=%h z=%h",
                       $realtime, got.crosses, got.x, got.y, got.z);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o = pending_cuts.size();
  end

endmodule

[tb/segment_w_hyperplane_slice_top_tb.sv]
// ----------------------------------------------------------------------------
// segment_w_hyperplane_slice_top_tb: testbench for the segment slice block
// Drives directed corner segments and then random segments, mostly strict
// crossings, with random and zero gaps between beats. A scoreboard module
// predicts and checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module segment_w_hyperplane_slice_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import segw_pkg::*;

  localparam int     RandomSegments = 700;
  localparam int     BurstLength    = 40;
  localparam coord_t CoordMax       = 32'h7fff_ffff;
  localparam coord_t CoordMin       = 32'h8000_0000;
  localparam coord_t One            = 32'h0001_0000;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  coord_t start_x_i, start_y_i, start_z_i, start_w_i;
  coord_t end_x_i, end_y_i, end_z_i, end_w_i;
  logic   done_o;
  logic   crosses_o;
  coord_t cut_x_o, cut_y_o, cut_z_o;
  int     fail_count;
  int     pending;
  bit     burst_mode;

  segment_w_hyperplane_slice_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .start_z_i (start_z_i),
    .start_w_i (start_w_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .end_z_i   (end_z_i),
    .end_w_i   (end_w_i),
    .done_o    (done_o),
    .crosses_o (crosses_o),
    .cut_x_o   (cut_x_o),
    .cut_y_o   (cut_y_o),
    .cut_z_o   (cut_z_o)
  );

  segw_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .start_w_i    (start_w_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .end_z_i      (end_z_i),
    .end_w_i      (end_w_i),
    .done_i       (done_o),
    .crosses_i    (crosses_o),
    .cut_x_i      (cut_x_o),
    .cut_y_i      (cut_y_o),
    .cut_z_i      (cut_z_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #200_000;
    $display("segment_w_hyperplane_slice_top: mismatch");
    $finish;
  end

  // Send one segment beat, hold until accepted, then idle for a drawn gap
  task automatic send_segment(coord_t sx, coord_t sy, coord_t sz, coord_t sw,
                              coord_t ex, coord_t ey, coord_t ez, coord_t ew);
    int gap;
    @(negedge clk_i);
    start_x_i = sx;
    start_y_i = sy;
    start_z_i = sz;
    start_w_i = sw;
    end_x_i   = ex;
    end_y_i   = ey;
    end_z_i   = ez;
    end_w_i   = ew;
    start     = 1'b1;
    do @(posedge clk_i); while (busy);
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Coordinate with extra weight on the corners
  function automatic coord_t draw_coord();
    case ($urandom_range(0, 11))
      0:       return CoordMax;
      1:       return CoordMin;
      2:       return '0;
      3:       return coord_t'($urandom_range(0, 1) ? -1 : 1);
      4:       return coord_t'($signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Nonzero weight magnitude, small or full range, with the given sign
  function automatic coord_t draw_weight(bit neg);
    coord_t w;
    if ($urandom_range(0, 3) == 0) w = coord_t'($urandom_range(1, 255));
    else w = coord_t'($urandom());
    w[CoordBits-1] = 1'b0;
    if (w == 0) w = 1;
    return neg ? (coord_t'(0) - w) : w;
  endfunction

  initial begin
    coord_t sw, ew;
    bit     neg;
    int     kind;
    start      = 1'b0;
    start_x_i  = '0;
    start_y_i  = '0;
    start_z_i  = '0;
    start_w_i  = '0;
    end_x_i    = '0;
    end_y_i    = '0;
    end_z_i    = '0;
    end_w_i    = '0;
    burst_mode = 1'b0;
    rst_ni     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: no crossing with zero, equal-sign and both-zero weights
    send_segment('0, '0, '0, '0, '0, '0, '0, '0);
    send_segment(One, One, One, '0, CoordMax, CoordMin, One, -One);
    send_segment(One, One, One, One, CoordMax, CoordMin, One, '0);
    send_segment(One, -One, One, One, CoordMax, CoordMin, One, 32'h0003_0000);
    send_segment(CoordMax, CoordMin, '1, -One, CoordMin, CoordMax, '1, CoordMin);
    send_segment(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax,
                 CoordMax);
    // Directed: simple crossings, equal weights and unequal weights in both orders
    send_segment('0, One, -One, One, 32'h0004_0000, One, One, -One);
    send_segment('0, '0, '0, One, 32'h0003_0000, '0, '0, 32'hfffd_0000);
    send_segment('0, '0, '0, 32'hfffd_0000, 32'h0003_0000, '0, '0, One);
    // Directed: small quotients truncate toward zero
    send_segment(-1, -1, 1, 1, '0, '0, '0, -2);
    send_segment(-2, 2, -1, -1, '0, '0, '0, 2);
    // Directed: extreme weights and coordinates
    send_segment(CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, CoordMin, CoordMin,
                 CoordMax);
    send_segment(CoordMin, CoordMin, CoordMin, CoordMax, CoordMin, CoordMin, CoordMax,
                 CoordMin);
    send_segment(CoordMax, CoordMax, CoordMin, 1, CoordMax, CoordMax, CoordMax, CoordMin);
    send_segment(CoordMin, CoordMax, '0, CoordMin, CoordMax, CoordMin, '0, 1);
    send_segment(CoordMax, CoordMin, 1, -1, CoordMin, CoordMax, -1, 1);
    send_segment('1, '1, '1, CoordMax, '1, '1, '1, -1);
    send_segment(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'h1234_5678,
                 32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0, 32'h8765_4321);

    // Random: mostly strict crossings, some same-sign and zero weights
    for (int i = 0; i < RandomSegments; i++) begin
      if (i % BurstLength == 0) burst_mode = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 19);
      neg  = $urandom_range(0, 1);
      if (kind < 15) begin
        sw = draw_weight(neg);
        ew = draw_weight(!neg);
      end else if (kind < 18) begin
        sw = draw_weight(neg);
        ew = draw_weight(neg);
      end else begin
        sw = $urandom_range(0, 1) ? coord_t'($urandom()) : '0;
        ew = (sw == 0 || $urandom_range(0, 1)) ? '0 : coord_t'($urandom());
        if ($urandom_range(0, 1)) begin
          {sw, ew} = {ew, sw};
        end
      end
      send_segment(draw_coord(), draw_coord(), draw_coord(), sw,
                   draw_coord(), draw_coord(), draw_coord(), ew);
    end

    // Drain and watch for stray result beats
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("segment_w_hyperplane_slice_top: match");
    end else begin
      $display("segment_w_hyperplane_slice_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/segw_pkg.sv
hw/rtl/segw_div.sv
hw/rtl/segment_w_hyperplane_slice_top.sv
tb/segw_result_checker.sv
tb/segment_w_hyperplane_slice_top_tb.sv
